// ===== rtl/i2p_pkg.sv =====
package i2p_pkg;

	// Result kinds carried on the master tuser
	typedef enum logic [1:0] {
		KIND_SYM = 2'd0,
		KIND_END = 2'd1,
		KIND_ERR = 2'd2
	} kind_t;

	// Character classes of the held input character
	typedef enum logic [2:0] {
		CLS_OTHER  = 3'd0,
		CLS_ALNUM  = 3'd1,
		CLS_LPAREN = 3'd2,
		CLS_RPAREN = 3'd3,
		CLS_OP     = 3'd4
	} chr_class_t;

	// Source of an emitted record
	typedef enum logic [1:0] {
		SEL_CHAR = 2'd0,
		SEL_TOP  = 2'd1,
		SEL_END  = 2'd2,
		SEL_ERR  = 2'd3
	} emit_sel_t;

	localparam logic [7:0] CH_PLUS   = 8'h2B;
	localparam logic [7:0] CH_MINUS  = 8'h2D;
	localparam logic [7:0] CH_STAR   = 8'h2A;
	localparam logic [7:0] CH_SLASH  = 8'h2F;
	localparam logic [7:0] CH_CARET  = 8'h5E;
	localparam logic [7:0] CH_LPAREN = 8'h28;
	localparam logic [7:0] CH_RPAREN = 8'h29;

	// Commands from controller to datapath
	typedef struct packed {
		logic      load;
		logic      push;
		logic      pop;
		logic      emit;
		emit_sel_t sel;
		logic      set_fail;
		logic      clear;
		logic      finish;
	} cmd_t;

	// Status from datapath to controller
	typedef struct packed {
		chr_class_t cls;
		logic       last;
		logic       failed;
		logic       empty;
		logic       full;
		logic       top_lparen;
		logic       pop_ok;
		logic       emit_ok;
	} status_t;

	// Operator precedence; zero for anything that is not an operator
	function automatic logic [1:0] prec_of(input logic [7:0] c);
		logic [1:0] p;
		p = 2'd0;
		if (c == CH_PLUS || c == CH_MINUS) p = 2'd1;
		else if (c == CH_STAR || c == CH_SLASH) p = 2'd2;
		else if (c == CH_CARET) p = 2'd3;
		return p;
	endfunction

	function automatic chr_class_t class_of(input logic [7:0] c);
		chr_class_t k;
		k = CLS_OTHER;
		if ((c >= 8'h30 && c <= 8'h39) || (c >= 8'h41 && c <= 8'h5A) ||
		    (c >= 8'h61 && c <= 8'h7A)) k = CLS_ALNUM;
		else if (c == CH_LPAREN) k = CLS_LPAREN;
		else if (c == CH_RPAREN) k = CLS_RPAREN;
		else if (prec_of(c) != 2'd0) k = CLS_OP;
		return k;
	endfunction

endpackage

// ===== rtl/infix_to_postfix_converter.sv =====
// Channel  Dir  Fields
// s_*      in   tdata[7:0] char_in, tlast is_final
// m_*      out  tdata[7:0] char_out, tuser[1:0] kind, tlast run_end
//
// An item passes the states accept, decode, end-of-expression check and close,
// and stays in decode or check while it pops operators to the output; after
// each pop the new top comes from the registered stack read.
// Reset (arst_n low) empties the stack and clears the error flag.
// A stalled m_tready holds the controller at the next record it must send.
// s_tready is high only while no item is in work.
module infix_to_postfix_converter #(
	parameter int STACK_DEPTH = 32
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       s_tvalid,
	output logic       s_tready,
	input  logic [7:0] s_tdata,  // [7:0] char_in
	input  logic       s_tlast,
	output logic       m_tvalid,
	input  logic       m_tready,
	output logic [7:0] m_tdata,  // [7:0] char_out
	output logic [1:0] m_tuser,  // [1:0] kind
	output logic       m_tlast
);

	i2p_pkg::cmd_t    cmd;
	i2p_pkg::status_t sts;

	i2p_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	i2p_dp #(
		.STACK_DEPTH (STACK_DEPTH)
	) u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.sts      (sts),
		.char_in  (s_tdata),
		.is_final (s_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

endmodule

// ===== rtl/i2p_dp.sv =====
module i2p_dp #(
	parameter int STACK_DEPTH = 32
) (
	input  logic              clk,
	input  logic              arst_n,
	input  i2p_pkg::cmd_t     cmd,
	output i2p_pkg::status_t  sts,
	input  logic [7:0]        char_in,
	input  logic              is_final,
	output logic              m_tvalid,
	input  logic              m_tready,
	output logic [7:0]        m_tdata,
	output logic [1:0]        m_tuser,
	output logic              m_tlast
);

	localparam int CW = $clog2(STACK_DEPTH + 1);
	localparam int AW = $clog2(STACK_DEPTH);

	logic [7:0]    char_q;
	logic          last_q;
	logic          fail_q;
	logic [CW-1:0] count_q;
	logic [CW-1:0] count_d;
	logic [CW-1:0] count_m1;
	logic [7:0]    top_q;
	logic [7:0]    stack_mem [STACK_DEPTH];

	logic          hold_valid_q;
	logic [7:0]    hold_char_q;
	logic [1:0]    hold_kind_q;
	logic          out_valid_q;
	logic [7:0]    out_char_q;
	logic [1:0]    out_kind_q;
	logic          out_last_q;

	logic          out_free;
	logic [7:0]    new_char;
	logic [1:0]    new_kind;

	// Held input transaction
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			char_q <= char_in;
			last_q <= is_final;
		end
	end

	// Stack depth and error flag
	always_comb begin
		count_d = count_q;
		if (cmd.clear) count_d = '0;
		else if (cmd.push) count_d = count_q + CW'(1);
		else if (cmd.pop) count_d = count_q - CW'(1);
	end
	assign count_m1 = count_d - CW'(1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			fail_q  <= 1'b0;
		end else begin
			count_q <= count_d;
			if (cmd.clear) fail_q <= 1'b0;
			else if (cmd.set_fail) fail_q <= 1'b1;
		end
	end

	// Stack memory; the read port follows the next top so top_q is always current
	always_ff @(posedge clk) begin
		if (cmd.push) stack_mem[count_q[AW-1:0]] <= char_q;
	end

	always_ff @(posedge clk) begin
		if (cmd.push) top_q <= char_q;
		else top_q <= stack_mem[count_m1[AW-1:0]];
	end

	// Status toward the controller
	assign out_free = !out_valid_q || m_tready;
	always_comb begin
		sts.cls        = i2p_pkg::class_of(char_q);
		sts.last       = last_q;
		sts.failed     = fail_q;
		sts.empty      = (count_q == '0);
		sts.full       = (count_q == CW'(STACK_DEPTH));
		sts.top_lparen = (top_q == i2p_pkg::CH_LPAREN);
		sts.pop_ok     = (i2p_pkg::prec_of(top_q) != 2'd0) &&
		                 (i2p_pkg::prec_of(top_q) >= i2p_pkg::prec_of(char_q));
		sts.emit_ok    = !hold_valid_q || out_free;
	end

	// Record selection
	always_comb begin
		unique case (cmd.sel)
			i2p_pkg::SEL_CHAR: begin
				new_char = char_q;
				new_kind = i2p_pkg::KIND_SYM;
			end
			i2p_pkg::SEL_TOP: begin
				new_char = top_q;
				new_kind = i2p_pkg::KIND_SYM;
			end
			i2p_pkg::SEL_END: begin
				new_char = 8'd0;
				new_kind = i2p_pkg::KIND_END;
			end
			default: begin
				new_char = 8'd0;
				new_kind = i2p_pkg::KIND_ERR;
			end
		endcase
	end

	// One record waits in the hold slot until it is known whether it ends the run
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_valid_q <= 1'b0;
			out_valid_q  <= 1'b0;
		end else begin
			if (cmd.emit) hold_valid_q <= 1'b1;
			else if (cmd.finish) hold_valid_q <= 1'b0;
			if ((cmd.emit || cmd.finish) && hold_valid_q) out_valid_q <= 1'b1;
			else if (m_tready) out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			hold_char_q <= new_char;
			hold_kind_q <= new_kind;
		end
		if ((cmd.emit || cmd.finish) && hold_valid_q) begin
			out_char_q <= hold_char_q;
			out_kind_q <= hold_kind_q;
			out_last_q <= cmd.finish;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_char_q;
	assign m_tuser  = out_kind_q;
	assign m_tlast  = out_last_q;

	// Checks
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(STACK_DEPTH))
		else $error("stack count above depth");
	a_no_push_full: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.push |-> count_q != CW'(STACK_DEPTH))
		else $error("push onto full stack");
	a_no_pop_empty: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.pop |-> count_q != '0)
		else $error("pop from empty stack");
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.emit || cmd.finish) && hold_valid_q |-> out_free)
		else $error("output register overwritten while stalled");

endmodule

// ===== rtl/i2p_ctrl.sv =====
module i2p_ctrl (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             s_tvalid,
	output logic             s_tready,
	input  i2p_pkg::status_t sts,
	output i2p_pkg::cmd_t    cmd
);

	typedef enum logic [3:0] {
		ST_IDLE   = 4'b0001,
		ST_HANDLE = 4'b0010,
		ST_FLUSH  = 4'b0100,
		ST_DONE   = 4'b1000
	} state_t;

	state_t state_q;
	state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= ST_IDLE;
		else state_q <= state_d;
	end

	assign s_tready = (state_q == ST_IDLE);

	// Next state and datapath commands
	always_comb begin
		state_d      = state_q;
		cmd          = '0;
		cmd.sel      = i2p_pkg::SEL_CHAR;
		unique case (state_q)
			ST_IDLE: begin
				if (s_tvalid) begin
					cmd.load = 1'b1;
					state_d  = ST_HANDLE;
				end
			end
			ST_HANDLE: begin
				if (sts.failed) begin
					state_d = ST_FLUSH;
				end else begin
					unique case (sts.cls)
						i2p_pkg::CLS_ALNUM: begin
							if (sts.emit_ok) begin
								cmd.emit = 1'b1;
								state_d  = ST_FLUSH;
							end
						end
						i2p_pkg::CLS_LPAREN: begin
							if (!sts.full) begin
								cmd.push = 1'b1;
								state_d  = ST_FLUSH;
							end else if (sts.emit_ok) begin
								cmd.emit     = 1'b1;
								cmd.sel      = i2p_pkg::SEL_ERR;
								cmd.set_fail = 1'b1;
								state_d      = ST_FLUSH;
							end
						end
						i2p_pkg::CLS_RPAREN: begin
							if (sts.empty) begin
								if (sts.emit_ok) begin
									cmd.emit     = 1'b1;
									cmd.sel      = i2p_pkg::SEL_ERR;
									cmd.set_fail = 1'b1;
									state_d      = ST_FLUSH;
								end
							end else if (sts.top_lparen) begin
								cmd.pop = 1'b1;
								state_d = ST_FLUSH;
							end else if (sts.emit_ok) begin
								cmd.pop  = 1'b1;
								cmd.emit = 1'b1;
								cmd.sel  = i2p_pkg::SEL_TOP;
							end
						end
						i2p_pkg::CLS_OP: begin
							if (!sts.empty && sts.pop_ok) begin
								if (sts.emit_ok) begin
									cmd.pop  = 1'b1;
									cmd.emit = 1'b1;
									cmd.sel  = i2p_pkg::SEL_TOP;
								end
							end else if (!sts.full) begin
								cmd.push = 1'b1;
								state_d  = ST_FLUSH;
							end else if (sts.emit_ok) begin
								cmd.emit     = 1'b1;
								cmd.sel      = i2p_pkg::SEL_ERR;
								cmd.set_fail = 1'b1;
								state_d      = ST_FLUSH;
							end
						end
						default: state_d = ST_FLUSH;
					endcase
				end
			end
			ST_FLUSH: begin
				// Empty the stack on the last character of an expression
				priority if (!sts.last) begin
					state_d = ST_DONE;
				end else if (sts.failed) begin
					cmd.clear = 1'b1;
					state_d   = ST_DONE;
				end else if (sts.empty) begin
					if (sts.emit_ok) begin
						cmd.emit  = 1'b1;
						cmd.sel   = i2p_pkg::SEL_END;
						cmd.clear = 1'b1;
						state_d   = ST_DONE;
					end
				end else if (sts.top_lparen) begin
					if (sts.emit_ok) begin
						cmd.emit  = 1'b1;
						cmd.sel   = i2p_pkg::SEL_ERR;
						cmd.clear = 1'b1;
						state_d   = ST_DONE;
					end
				end else if (sts.emit_ok) begin
					cmd.pop  = 1'b1;
					cmd.emit = 1'b1;
					cmd.sel  = i2p_pkg::SEL_TOP;
				end
			end
			ST_DONE: begin
				// Release the held record marked as the end of the run
				if (sts.emit_ok) begin
					cmd.finish = 1'b1;
					state_d    = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// Checks
	a_load_idle: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load |-> state_q == ST_IDLE)
		else $error("transaction loaded outside idle");
	a_push_pop: assert property (@(posedge clk) disable iff (!arst_n)
		!(cmd.push && cmd.pop))
		else $error("push and pop in one cycle");
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_DONE && sts.emit_ok |=> state_q == ST_IDLE)
		else $error("run not closed");

endmodule

// ===== tb/sv/testbench.sv =====
module testbench;

	localparam int STACK_DEPTH = 32;
	localparam int QUIET_LIMIT = 4000;
	localparam int TARGET_CHARS = 400;
	localparam logic [7:0] CH_TAB = 8'h09;
	localparam logic [7:0] CH_BLANK = 8'h20;

	// One infix character waiting to be sent
	typedef struct packed {
		logic [7:0] ch;
		logic       fin;
		logic [1:0] phase;
		logic       drain;
	} infix_char_t;

	// One postfix record as it should leave the block
	typedef struct packed {
		logic [7:0]     ch;
		i2p_pkg::kind_t kind;
		logic           fin;
	} postfix_rec_t;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       s_tvalid = 1'b0;
	logic       s_tready;
	logic [7:0] s_tdata = 8'h00;  // [7:0] char_in
	logic       s_tlast = 1'b0;
	logic       m_tvalid;
	logic       m_tready = 1'b0;
	logic [7:0] m_tdata;          // [7:0] char_out
	logic [1:0] m_tuser;          // [1:0] kind
	logic       m_tlast;

	infix_char_t  infix_q[$];
	postfix_rec_t pending_postfix[$];
	postfix_rec_t step_recs[$];

	// Operator stack mirror
	logic [7:0] ops[STACK_DEPTH];
	int         ops_cnt = 0;
	bit         expr_bad = 1'b0;

	logic       src_taken = 1'b0;
	logic [1:0] cur_phase = 2'd0;
	int         errors = 0;
	int         quiet = 0;

	// Stimulus builder state
	logic [1:0] gen_phase = 2'd0;
	logic       gen_drain = 1'b0;
	int         gen_count = 0;

	infix_to_postfix_converter #(.STACK_DEPTH(STACK_DEPTH)) uut (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tlast(s_tlast),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tuser(m_tuser),
		.m_tlast(m_tlast)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// ---------------- postfix prediction ----------------

	function automatic int rank(input logic [7:0] c);
		int r;
		r = 0;
		if (c == i2p_pkg::CH_PLUS || c == i2p_pkg::CH_MINUS) r = 1;
		else if (c == i2p_pkg::CH_STAR || c == i2p_pkg::CH_SLASH) r = 2;
		else if (c == i2p_pkg::CH_CARET) r = 3;
		return r;
	endfunction

	function automatic bit is_symbol(input logic [7:0] c);
		return (c >= "0" && c <= "9") || (c >= "A" && c <= "Z") ||
			(c >= "a" && c <= "z");
	endfunction

	function automatic void emit_rec(input logic [7:0] c, input i2p_pkg::kind_t k);
		postfix_rec_t r;
		r.ch = c;
		r.kind = k;
		r.fin = 1'b0;
		step_recs.push_back(r);
	endfunction

	function automatic void mark_bad();
		emit_rec(8'h00, i2p_pkg::KIND_ERR);
		expr_bad = 1'b1;
	endfunction

	function automatic void push_op(input logic [7:0] c);
		if (ops_cnt >= STACK_DEPTH) begin
			mark_bad();
		end else begin
			ops[ops_cnt] = c;
			ops_cnt++;
		end
	endfunction

	// Works out the postfix records one accepted character causes
	function automatic void convert_char(input logic [7:0] c, input logic fin);
		postfix_rec_t r;
		bit stop;
		step_recs.delete();
		if (!expr_bad && c != CH_BLANK && c != CH_TAB) begin
			if (is_symbol(c)) begin
				emit_rec(c, i2p_pkg::KIND_SYM);
			end else if (c == i2p_pkg::CH_LPAREN) begin
				push_op(c);
			end else if (c == i2p_pkg::CH_RPAREN) begin
				while (ops_cnt > 0 && ops[ops_cnt - 1] != i2p_pkg::CH_LPAREN) begin
					ops_cnt--;
					emit_rec(ops[ops_cnt], i2p_pkg::KIND_SYM);
				end
				if (ops_cnt == 0) mark_bad();
				else ops_cnt--;
			end else if (rank(c) > 0) begin
				// left-assoc: pop equal or higher precedence first
				while (ops_cnt > 0 && rank(ops[ops_cnt - 1]) >= rank(c)) begin
					ops_cnt--;
					emit_rec(ops[ops_cnt], i2p_pkg::KIND_SYM);
				end
				push_op(c);
			end
		end
		if (fin) begin
			if (!expr_bad) begin
				stop = 1'b0;
				while (ops_cnt > 0 && !stop) begin
					ops_cnt--;
					if (ops[ops_cnt] == i2p_pkg::CH_LPAREN) begin
						mark_bad();
						stop = 1'b1;
					end else begin
						emit_rec(ops[ops_cnt], i2p_pkg::KIND_SYM);
					end
				end
				if (!stop) emit_rec(8'h00, i2p_pkg::KIND_END);
			end
			ops_cnt = 0;
			expr_bad = 1'b0;
		end
		for (int i = 0; i < step_recs.size(); i++) begin
			r = step_recs[i];
			r.fin = (i == step_recs.size() - 1);
			pending_postfix.push_back(r);
		end
	endfunction

	// ---------------- stimulus builders ----------------

	function automatic void add_char(input logic [7:0] c, input logic fin);
		infix_char_t t;
		t.ch = c;
		t.fin = fin;
		t.phase = gen_phase;
		t.drain = gen_drain;
		gen_drain = 1'b0;
		gen_count++;
		infix_q.push_back(t);
	endfunction

	function automatic void add_text(input string s, input logic fin_at_end);
		for (int i = 0; i < s.len(); i++)
			add_char(s[i], fin_at_end && (i == s.len() - 1));
	endfunction

	function automatic logic [7:0] pick_op();
		logic [7:0] c;
		case ($urandom_range(4))
			0: c = i2p_pkg::CH_PLUS;
			1: c = i2p_pkg::CH_MINUS;
			2: c = i2p_pkg::CH_STAR;
			3: c = i2p_pkg::CH_SLASH;
			default: c = i2p_pkg::CH_CARET;
		endcase
		return c;
	endfunction

	function automatic logic [7:0] pick_alnum();
		int r;
		r = $urandom_range(61);
		if (r < 10) return 8'(8'h30 + r);
		else if (r < 36) return 8'(8'h41 + r - 10);
		else return 8'(8'h61 + r - 36);
	endfunction

	// Ends an expression: flag its last char, or append a blank, tab or any byte
	function automatic void close_expr();
		infix_char_t t;
		case ($urandom_range(4))
			0: add_char(CH_BLANK, 1'b1);
			1: add_char(CH_TAB, 1'b1);
			2: add_char(8'($urandom_range(255)), 1'b1);
			default: begin
				t = infix_q.pop_back();
				t.fin = 1'b1;
				infix_q.push_back(t);
			end
		endcase
	endfunction

	// Well-formed expression with random operands, operators and nesting
	function automatic void gen_expr();
		int depth_open;
		int terms;
		depth_open = 0;
		terms = $urandom_range(1, 8);
		for (int i = 0; i < terms; i++) begin
			if (i > 0) add_char(pick_op(), 1'b0);
			while (depth_open < 5 && $urandom_range(3) == 0) begin
				add_char(i2p_pkg::CH_LPAREN, 1'b0);
				depth_open++;
			end
			add_char(pick_alnum(), 1'b0);
			if ($urandom_range(9) == 0)
				add_char($urandom_range(1) ? CH_BLANK : CH_TAB, 1'b0);
			while (depth_open > 0 && $urandom_range(2) == 0) begin
				add_char(i2p_pkg::CH_RPAREN, 1'b0);
				depth_open--;
			end
		end
		while (depth_open > 0) begin
			add_char(i2p_pkg::CH_RPAREN, 1'b0);
			depth_open--;
		end
	endfunction

	// Long run of '(' near and past the stack depth
	function automatic void gen_nest();
		int n;
		int m;
		n = $urandom_range(STACK_DEPTH - 4, STACK_DEPTH + 2);
		m = $urandom_range(1) ? n : $urandom_range(n + 1);
		repeat (n) add_char(i2p_pkg::CH_LPAREN, 1'b0);
		add_char(pick_alnum(), 1'b0);
		repeat (m) add_char(i2p_pkg::CH_RPAREN, 1'b0);
		close_expr();
	endfunction

	// a op (b op (c ... : fills the stack with operators and parens
	function automatic void gen_ladder();
		int k;
		int m;
		k = $urandom_range(8, STACK_DEPTH / 2 + 2);
		m = $urandom_range(1) ? k : $urandom_range(k);
		add_char(pick_alnum(), 1'b0);
		repeat (k) begin
			add_char(pick_op(), 1'b0);
			add_char(i2p_pkg::CH_LPAREN, 1'b0);
			add_char(pick_alnum(), 1'b0);
		end
		repeat (m) add_char(i2p_pkg::CH_RPAREN, 1'b0);
		close_expr();
	endfunction

	// Expressions with a stray ')' or a missing one
	function automatic void gen_broken();
		case ($urandom_range(2))
			0: begin
				gen_expr();
				add_char(i2p_pkg::CH_RPAREN, 1'b0);
				gen_expr();
			end
			1: begin
				add_char(i2p_pkg::CH_LPAREN, 1'b0);
				gen_expr();
			end
			default: begin
				add_char(i2p_pkg::CH_RPAREN, 1'b0);
				gen_expr();
			end
		endcase
		close_expr();
	endfunction

	function automatic void gen_noise();
		repeat ($urandom_range(1, 5))
			add_char(8'($urandom_range(255)), $urandom_range(3) == 0);
	endfunction

	// ---------------- input driver ----------------

	always @(negedge clk) begin
		infix_char_t nxt;
		int idle;
		if (arst_n && (!s_tvalid || src_taken)) begin
			idle = 0;
			if (infix_q.size() > 0) begin
				nxt = infix_q[0];
				idle = (nxt.phase == 2'd0) ? 15 : (nxt.phase == 2'd1) ? 84 : 0;
			end
			if (infix_q.size() > 0 && !(nxt.drain && pending_postfix.size() != 0) &&
			    $urandom_range(99) >= idle) begin
				nxt = infix_q.pop_front();
				s_tvalid <= 1'b1;
				s_tdata <= nxt.ch;
				s_tlast <= nxt.fin;
				cur_phase <= nxt.phase;
			end else begin
				s_tvalid <= 1'b0;
				s_tdata <= 8'($urandom);
				s_tlast <= 1'($urandom);
			end
		end
	end

	// Output stall, by phase
	always @(negedge clk) begin
		int idle;
		idle = (cur_phase == 2'd0) ? 84 : (cur_phase == 2'd1) ? 15 : 0;
		m_tready <= arst_n && ($urandom_range(99) >= idle);
	end

	// ---------------- monitor, checker and watchdog ----------------

	always @(posedge clk) begin
		postfix_rec_t want;
		if (arst_n) begin
			src_taken <= s_tvalid && s_tready;
			if (s_tvalid && s_tready) convert_char(s_tdata, s_tlast);
			if (m_tvalid && m_tready) begin
				if (pending_postfix.size() == 0) begin
					errors++;
					$display("%0t unexpected transaction: expected none, %s",
						$time, $sformatf("got ch=%h kind=%0d last=%b",
						m_tdata, m_tuser, m_tlast));
				end else begin
					want = pending_postfix.pop_front();
					if (m_tdata !== want.ch || m_tuser !== want.kind ||
					    m_tlast !== want.fin) begin
						errors++;
						$display("%0t mismatch: expected ch=%h kind=%0d last=%b, %s",
							$time, want.ch, want.kind, want.fin,
							$sformatf("got ch=%h kind=%0d last=%b",
							m_tdata, m_tuser, m_tlast));
					end
				end
			end
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) quiet <= 0;
			else quiet <= quiet + 1;
			if (quiet >= QUIET_LIMIT) begin
				$display("%0t watchdog: no transaction for %0d cycles", $time, QUIET_LIMIT);
				$display("CHECK FAILED");
				$finish;
			end
		end
	end

	// ---------------- sequence ----------------

	initial begin
		int pick;
		logic [1:0] last_phase;

		// directed: precedence, nesting, blanks, errors, other bytes
		add_text("a+b*c", 1'b1);
		add_text("(Z -9)/z^\t0", 1'b1);
		gen_drain = 1'b1;
		add_text(")b+", 1'b1);
		add_text("(a+b", 1'b1);
		add_char(8'hFF, 1'b0);
		add_char(8'h00, 1'b0);
		add_char("@", 1'b0);
		add_char("x", 1'b1);
		add_char(CH_BLANK, 1'b1);

		// random: mostly well-formed, some deep, broken and noise
		last_phase = 2'd0;
		while (gen_count < TARGET_CHARS) begin
			gen_phase = (gen_count < TARGET_CHARS / 3) ? 2'd0 :
				(gen_count < 2 * TARGET_CHARS / 3) ? 2'd1 : 2'd2;
			if (gen_phase != last_phase || $urandom_range(19) == 0) gen_drain = 1'b1;
			last_phase = gen_phase;
			pick = $urandom_range(99);
			if (pick < 60) begin
				gen_expr();
				close_expr();
			end else if (pick < 67) begin
				gen_nest();
			end else if (pick < 74) begin
				gen_ladder();
			end else if (pick < 90) begin
				gen_broken();
			end else begin
				gen_noise();
			end
		end
		// make sure the last expression is closed
		add_char(CH_BLANK, 1'b1);

		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		while (infix_q.size() > 0 || s_tvalid || pending_postfix.size() > 0) @(negedge clk);
		repeat (40) @(negedge clk);

		if (errors == 0 && pending_postfix.size() == 0) begin
			$display("CHECK OK");
		end else begin
			$display("CHECK FAILED");
		end
		$finish;
	end

endmodule
